// File: design/mbe_pkg.sv
package mbe_pkg;

	// Default frame limits; the top level hands these down as parameters.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Fixed widths of the configuration port and of the result fields.
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_W     = 10;
	localparam int ALPHA_W   = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// Reset values of the size registers.
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

	// Input action codes.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Per-beat control word from the position sequencer to the evaluation stage.
	typedef struct packed {
		logic             live;        // beat does work (not an idle drain)
		logic             drain;       // flushes one pixel of the last row
		logic             emit;        // beat produces a result
		logic             first_col;   // column 0: left neighbour is off-frame
		logic             last_col;    // last column: right neighbour is off-frame
		logic             top_row;     // described pixel lies on row 0
		logic             below_edge;  // pixel below lies outside the frame
		logic             cur;         // nonzero flag of the incoming pixel
		logic [OUT_W-1:0] col;         // column of the described pixel
		logic [OUT_W-1:0] row;         // row of the described pixel
	} mbe_item_t;

endpackage

// File: design/mask_boundary_extract_top.sv
// Boundary extraction of a binary alpha mask, four-neighbour rule. Pixels
// enter in raster order, one per clock, and each beat returns at most one
// result: the verdict for the pixel one row above the pixel just taken, which
// leaves through stage one and then the result register after that pixel is
// accepted. Row 0 pixels give no result. After the last pixel of a frame,
// frame_width drain beats flush the last row, the final one flagged with
// frame_end; drain beats outside that window are swallowed. The nonzero
// flags of the two previous rows live in one line store of MAX_WIDTH flag
// pairs that is read when a beat is accepted and written back as the beat
// leaves stage one, with a write bypass covering narrow frames where both
// touch the same entry. Sustained rate is one beat per clock; the input
// stalls only while the evaluation stage is full and the result register is
// held by a stall downstream. There is no clearing pass after reset. Write the
// size registers only while no frame is in flight.
module mask_boundary_extract_top #(
	parameter int MAX_WIDTH  = mbe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mbe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbe_pkg::CFG_W-1:0]       cfg_data,
	// Pixel channel
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic                            action,
	input  logic [mbe_pkg::ALPHA_W-1:0]     pixel_alpha,
	// Result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            edge_on,
	output logic [mbe_pkg::OUT_W-1:0]       out_col,
	output logic [mbe_pkg::OUT_W-1:0]       out_row,
	output logic                            frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [mbe_pkg::CFG_W-1:0] frame_width_q, frame_height_q;

	mbe_pkg::mbe_item_t item, item_s1;
	logic [CW-1:0]      rd_addr_a, rd_addr_b, waddr_s1;
	logic [1:0]         rd_pair;
	logic               rd_mid_b;
	logic               s1_valid_q, s1_adv, take, mem_we;
	logic               left_q;
	logic               old_mid, lft, rgt, up, down, edge_d;

	logic                      res_valid_q, edge_q, end_q;
	logic [mbe_pkg::OUT_W-1:0] col_q, row_q;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mbe_pkg::FRAME_WIDTH_RST;
			frame_height_q <= mbe_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mbe_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mbe_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the evaluation stage moves on when the result register is free.
	assign s1_adv      = !res_valid_q || !result_stall;
	assign pixel_stall = s1_valid_q && !s1_adv;
	assign take        = pixel_valid && !pixel_stall;

	mbe_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.action       (action),
		.pixel_alpha  (pixel_alpha),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.item         (item),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b)
	);

	// Pixel beats write back the shifted flag pair as they leave stage one.
	assign mem_we = s1_valid_q && s1_adv && !item_s1.drain;

	mbe_flag_ram #(
		.DEPTH (MAX_WIDTH)
	) u_ram (
		.clk         (clk),
		.rd_en       (take),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b),
		.rd_pair_a_q (rd_pair),
		.rd_mid_b_q  (rd_mid_b),
		.wr_en       (mem_we),
		.wr_addr     (waddr_s1),
		.wr_pair     ({old_mid, item_s1.cur})
	);

	// Stage one: control word waits beside the line store read. It loads
	// whenever it is empty or its beat moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!pixel_stall) begin
			s1_valid_q <= take && item.live;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1  <= item;
			waddr_s1 <= rd_addr_a;
		end
	end

	// Previous-row flag of the column to the left, kept as the store is overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 1'b0;
		end else if (mem_we) begin
			left_q <= old_mid;
		end
	end

	// Boundary decision for the described pixel.
	always_comb begin
		old_mid = rd_pair[0];
		lft     = item_s1.first_col || !left_q;
		rgt     = item_s1.last_col || !rd_mid_b;
		up      = item_s1.top_row || !rd_pair[1];
		down    = item_s1.below_edge || !item_s1.cur;
		if (item_s1.drain) begin
			edge_d = old_mid;
		end else begin
			edge_d = old_mid && (lft || rgt || up || down);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= s1_valid_q && item_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q && item_s1.emit) begin
			edge_q <= edge_d;
			col_q  <= item_s1.col;
			row_q  <= item_s1.row;
			end_q  <= item_s1.drain && item_s1.last_col;
		end
	end

	assign result_valid = res_valid_q;
	assign edge_on      = edge_q;
	assign out_col      = col_q;
	assign out_row      = row_q;
	assign frame_end    = end_q;

	// A blocked stage one keeps its beat unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(item_s1)))
		else $error("stage one lost or changed a blocked beat");

	// Every drain beat that reaches stage one yields a result.
	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && item_s1.drain) |-> item_s1.emit)
		else $error("drain beat without a result");

	// The input only stalls while stage one is full and the result register is held by a stall.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (s1_valid_q && res_valid_q && result_stall))
		else $error("input stalled with room downstream");

endmodule

// File: design/mbe_flag_ram.sv
// Line store of flag pairs: bit 1 holds the flag two rows back, bit 0 the
// flag of the previous row. One write port, two registered read ports. A
// read at the address being written in the same cycle returns the new data.
module mbe_flag_ram #(
	parameter int DEPTH = mbe_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [1:0]    rd_pair_a_q,
	output logic          rd_mid_b_q,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_pair
);

	logic [1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_pair;
		end
	end

	// Read ports with write-first bypass.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr_a)) begin
				rd_pair_a_q <= wr_pair;
			end else begin
				rd_pair_a_q <= mem[rd_addr_a];
			end
			if (wr_en && (wr_addr == rd_addr_b)) begin
				rd_mid_b_q <= wr_pair[0];
			end else begin
				rd_mid_b_q <= mem[rd_addr_b][0];
			end
		end
	end

endmodule

// File: design/mbe_seq.sv
// Position sequencer: tracks the raster position of the next pixel and the
// drain of the last row, forms the line store addresses and the control word
// for each beat, and advances when a beat is taken.
module mbe_seq #(
	parameter int MAX_WIDTH  = mbe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mbe_pkg::MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         action,
	input  logic [mbe_pkg::ALPHA_W-1:0]  pixel_alpha,
	input  logic [mbe_pkg::CFG_W-1:0]    frame_width,
	input  logic [mbe_pkg::CFG_W-1:0]    frame_height,
	output mbe_pkg::mbe_item_t           item,
	output logic [CW-1:0]                rd_addr_a,
	output logic [CW-1:0]                rd_addr_b
);

	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int SW0 = $clog2(MAX_WIDTH + 1);
	localparam int SW1 = $clog2(MAX_HEIGHT + 1);
	localparam int SWA = (SW0 > SW1) ? SW0 : SW1;
	localparam int SW  = (SWA > mbe_pkg::CFG_W) ? SWA : mbe_pkg::CFG_W;

	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] drain_col_q;
	logic [RW-1:0] drain_row_q;
	logic          draining_q;

	logic [SW-1:0] fw_x, fh_x, w_eff, h_eff;
	logic [SW-1:0] col_x, row_x, dcol_x, drow_x, row_m1;
	logic          last_col, last_row, last_dcol, is_drain;

	// Clamp the size registers to the supported range.
	always_comb begin
		fw_x = SW'(frame_width);
		fh_x = SW'(frame_height);
		if (fw_x == '0) begin
			w_eff = SW'(1);
		end else if (fw_x > SW'(MAX_WIDTH)) begin
			w_eff = SW'(MAX_WIDTH);
		end else begin
			w_eff = fw_x;
		end
		if (fh_x == '0) begin
			h_eff = SW'(1);
		end else if (fh_x > SW'(MAX_HEIGHT)) begin
			h_eff = SW'(MAX_HEIGHT);
		end else begin
			h_eff = fh_x;
		end
	end

	// Position decode. The pixel counters are zero while the last row drains.
	always_comb begin
		is_drain  = (action == mbe_pkg::ACT_DRAIN);
		col_x     = SW'(in_col_q);
		row_x     = SW'(in_row_q);
		dcol_x    = SW'(drain_col_q);
		drow_x    = SW'(drain_row_q);
		row_m1    = row_x - SW'(1);
		last_col  = (col_x + SW'(1)) >= w_eff;
		last_row  = (row_x + SW'(1)) >= h_eff;
		last_dcol = (dcol_x + SW'(1)) >= w_eff;
	end

	// Control word and line store addresses for the beat on offer.
	always_comb begin
		item.cur = (pixel_alpha != '0);
		if (is_drain) begin
			item.live       = draining_q;
			item.drain      = 1'b1;
			item.emit       = 1'b1;
			item.first_col  = (drain_col_q == '0);
			item.last_col   = last_dcol;
			item.top_row    = (drain_row_q == '0);
			item.below_edge = 1'b1;
			item.col        = dcol_x[mbe_pkg::OUT_W-1:0];
			item.row        = drow_x[mbe_pkg::OUT_W-1:0];
			rd_addr_a       = drain_col_q;
		end else begin
			item.live       = 1'b1;
			item.drain      = 1'b0;
			item.emit       = (in_row_q != '0);
			item.first_col  = (in_col_q == '0);
			item.last_col   = last_col;
			item.top_row    = (in_row_q == RW'(1));
			item.below_edge = (row_x >= h_eff);
			item.col        = col_x[mbe_pkg::OUT_W-1:0];
			item.row        = row_m1[mbe_pkg::OUT_W-1:0];
			rd_addr_a       = in_col_q;
		end
		if (in_col_q == CW'(MAX_WIDTH - 1)) begin
			rd_addr_b = '0;
		end else begin
			rd_addr_b = in_col_q + CW'(1);
		end
	end

	// Advance the position on each beat taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			drain_col_q <= '0;
			drain_row_q <= '0;
			draining_q  <= 1'b0;
		end else if (take) begin
			if (is_drain) begin
				if (draining_q) begin
					if (last_dcol) begin
						draining_q  <= 1'b0;
						drain_col_q <= '0;
					end else begin
						drain_col_q <= drain_col_q + CW'(1);
					end
				end
			end else begin
				draining_q  <= 1'b0;
				drain_col_q <= '0;
				if (last_col) begin
					in_col_q <= '0;
					if (last_row) begin
						draining_q  <= 1'b1;
						drain_row_q <= in_row_q;
						in_row_q    <= '0;
					end else begin
						in_row_q <= in_row_q + RW'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
		end
	end

endmodule
